@@ hdl/pew_pkg.sv @@
package pew_pkg;

  localparam int DEF_CHANNELS = 60;
  localparam int DEF_TASKS    = 64;

  localparam int CHAN_W  = 6;
  localparam int TASK_W  = 6;
  localparam int TIME_W  = 32;
  localparam int WOKEN_W = 64;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [CHAN_W-1:0] LAST_CHAN   = 6'd59;
  localparam logic [TIME_W-1:0] PERIOD_STEP = 32'd100;
  localparam logic [TIME_W-1:0] LAST_PERIOD = 32'd9000;

  typedef enum logic {
    OP_WAIT = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Period of a channel in milliseconds: steps of 100 ms, except the last channel.
  function automatic logic [TIME_W-1:0] period_of(input logic [CHAN_W-1:0] chan);
    logic [TIME_W-1:0] p;
    if (chan == LAST_CHAN) begin
      p = LAST_PERIOD;
    end else begin
      p = TIME_W'(PERIOD_STEP * ({26'd0, chan} + 32'd1));
    end
    return p;
  endfunction

endpackage

@@ hdl/periodic_device_event_waker.sv @@
// Periodic device event waker.
// Input channel (in_*): one word per request. in_tuser selects the operation:
// a wait adds task in_tdata[11:6] to the waiter set of channel in_tdata[5:0];
// a tick carries the current time in milliseconds in in_tdata[43:12].
// A wait gives no result; a tick gives exactly one result word on out_*:
// the mask of woken tasks in out_tdata and the reschedule flag in out_tuser.
// Channel state (next match time and waiter mask) lives in on-chip memory with
// a registered read; an in-range wait reads, modifies and writes back its entry.
// Such a wait passes through S_WAIT, where the entry is written back. A tick sweeps
// the channels one per cycle through the memory port, reading every entry and
// writing back those that hit, then goes to S_DONE to hand over its result.
// One request is in flight at a time; in_tready is low while it is worked on.
// The result sits in an output register, so a new request is accepted while a
// result waits; a tick that finishes while the previous result is still not
// taken holds until out_tready frees the register.
// Reset (rst_n low, synchronous) returns every channel to its own period with
// an empty waiter set at once, through per-entry valid flags.
module periodic_device_event_waker
  import pew_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int TASKS    = DEF_TASKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // channel[5:0], task_id[11:6], now_ms[43:12]
  input  logic [0:0]            in_tuser,   // operation[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // woken_tasks[63:0]
  output logic [0:0]            out_tuser   // reschedule[0]
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int TIDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  chan_r;
  logic [TIDX_W-1:0]  task_r;
  logic [TIME_W-1:0]  now_r;
  logic [CNT_W-1:0]   issue_cnt_r;
  logic               proc_v_r;
  logic [ADDR_W-1:0]  proc_addr_r;
  logic [TASKS-1:0]   woken_r;
  logic               out_valid_r;
  logic [WOKEN_W-1:0] out_woken_r;
  logic               out_resched_r;

  logic [CHAN_W-1:0]  in_chan;
  logic [TASK_W-1:0]  in_task;
  logic [TIME_W-1:0]  in_now;
  logic               in_fire;
  logic               wait_ok;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TIME_W-1:0]  rd_match;
  logic [TASKS-1:0]   rd_mask;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [TIME_W-1:0]  wr_match;
  logic [TASKS-1:0]   wr_mask;

  logic               hit;
  logic [TIME_W-1:0]  reload;
  logic [TASKS-1:0]   woken_nxt;
  logic               more;
  logic               out_load;

  assign in_chan = in_tdata[5:0];
  assign in_task = in_tdata[11:6];
  assign in_now  = in_tdata[43:12];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign wait_ok   = ({1'b0, in_chan} < 7'(CHANNELS)) && ({1'b0, in_task} < 7'(TASKS));

  assign hit       = (rd_match <= now_r);
  assign reload    = now_r + period_of(CHAN_W'(proc_addr_r));
  assign woken_nxt = woken_r | (hit ? rd_mask : '0);
  assign more      = (issue_cnt_r < CNT_W'(CHANNELS));

  // The finished tick moves into the output register once it is free or being taken.
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = issue_cnt_r[ADDR_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = proc_addr_r;
    wr_match = reload;
    wr_mask  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_tuser[0]) == OP_TICK) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end else if (wait_ok) begin
            rd_en   = 1'b1;
            rd_addr = in_chan[ADDR_W-1:0];
          end
        end
      end
      S_WAIT: begin
        wr_en    = 1'b1;
        wr_addr  = chan_r;
        wr_match = rd_match;
        wr_mask  = rd_mask | (TASKS'(1) << task_r);
      end
      S_SWEEP: begin
        rd_en = more;
        wr_en = proc_v_r && hit;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      issue_cnt_r   <= '0;
      proc_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (op_t'(in_tuser[0]) == OP_TICK) begin
              now_r       <= in_now;
              woken_r     <= '0;
              proc_v_r    <= 1'b1;
              proc_addr_r <= '0;
              issue_cnt_r <= CNT_W'(1);
              state_r     <= S_SWEEP;
            end else if (wait_ok) begin
              chan_r  <= in_chan[ADDR_W-1:0];
              task_r  <= in_task[TIDX_W-1:0];
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          state_r <= S_IDLE;
        end
        S_SWEEP: begin
          woken_r <= woken_nxt;
          if (more) begin
            proc_addr_r <= issue_cnt_r[ADDR_W-1:0];
            issue_cnt_r <= issue_cnt_r + CNT_W'(1);
          end else begin
            proc_v_r <= 1'b0;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_woken_r   <= WOKEN_W'(woken_r);
            out_resched_r <= |woken_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  pew_chan_mem #(
    .CHANNELS(CHANNELS),
    .TASKS   (TASKS),
    .ADDR_W  (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_match(rd_match),
    .rd_mask (rd_mask),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_match(wr_match),
    .wr_mask (wr_mask)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_woken_r;
  assign out_tuser[0] = out_resched_r;

  // A write never lands on the entry being read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same channel entry");

  a_resched_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata != '0)))
    else $error("reschedule flag disagrees with woken mask");

  a_sweep_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (proc_v_r && (issue_cnt_r <= CNT_W'(CHANNELS))))
    else $error("sweep counter out of range");

  a_done_follows_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_DONE) |-> ($past(state_r) == S_SWEEP))
    else $error("result stage entered without a sweep");

endmodule

@@ hdl/pew_chan_mem.sv @@
module pew_chan_mem
  import pew_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int TASKS    = DEF_TASKS,
  parameter int ADDR_W   = (DEF_CHANNELS > 1) ? $clog2(DEF_CHANNELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [TIME_W-1:0] rd_match,
  output logic [TASKS-1:0]  rd_mask,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TIME_W-1:0] wr_match,
  input  logic [TASKS-1:0]  wr_mask
);

  logic [TIME_W-1:0] match_mem [CHANNELS];
  logic [TASKS-1:0]  mask_mem  [CHANNELS];
  logic [CHANNELS-1:0] valid_r;

  logic [TIME_W-1:0] match_q_r;
  logic [TASKS-1:0]  mask_q_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      match_mem[wr_addr] <= wr_match;
      mask_mem[wr_addr]  <= wr_mask;
    end
    if (rd_en) begin
      match_q_r <= match_mem[rd_addr];
      mask_q_r  <= mask_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // An entry never written reads as its reset value: own period, no waiters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_match = rd_vld_r ? match_q_r : period_of(CHAN_W'(rd_addr_r));
  assign rd_mask  = rd_vld_r ? mask_q_r : '0;

endmodule
